// ----- src/circular_fifo_queue_defines.svh -----
// Assertion macros for the circular FIFO queue.
// Used by the top level only; no other dependencies.
`ifndef CIRCULAR_FIFO_QUEUE_DEFINES_SVH
`define CIRCULAR_FIFO_QUEUE_DEFINES_SVH
`ifndef SYNTHESIS
`define CFQ_ASSERT(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define CFQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CFQ_ASSERT(lbl, clk, rst, cond, msg)
`define CFQ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/cfq_pkg.sv -----
// Package for the circular FIFO queue: sizes, operation codes, cell control.
// No dependencies.
package cfq_pkg;
   localparam int MAX_DEPTH = 1024;
   localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
   localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
   localparam int CAP_W     = 11;
   localparam int WORD_W    = 32;
   localparam int KIND_W    = 2;

   localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd2;

   localparam logic [CNT_W-1:0] CAP_RESET =
      CNT_W'((MAX_DEPTH < 1024) ? MAX_DEPTH : 1024);

   typedef struct packed {
      logic              pop;
      logic              push;
      logic [CNT_W-1:0]  count;
      logic [WORD_W-1:0] push_word;
   } cell_ctl_type;
endpackage

// ----- src/cfq_if.sv -----
// Valid/ready channel interfaces for the circular FIFO queue.
// Depends on cfq_pkg.
interface cfq_req_if;
   logic                              valid;
   logic                              ready;
   logic [cfq_pkg::KIND_W-1:0]        kind;
   logic signed [cfq_pkg::WORD_W-1:0] push_value;
   modport source (output valid, output kind, output push_value, input ready);
   modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface cfq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              accepted;
   logic signed [cfq_pkg::WORD_W-1:0] head_value;
   logic signed [cfq_pkg::WORD_W-1:0] tail_value;
   logic                              empty_flag;
   logic                              full_flag;
   modport source (output valid, output accepted, output head_value, output tail_value,
                   output empty_flag, output full_flag, input ready);
   modport sink   (input valid, input accepted, input head_value, input tail_value,
                   input empty_flag, input full_flag, output ready);
endinterface

// ----- src/cfq_cell.sv -----
// One storage cell of the queue chain: holds one word, shifts from its
// upper neighbor on a pop, loads the pushed word when it is the fill slot. Uses cfq_pkg.
module cfq_cell (
   input  logic                         clock,
   input  cfq_pkg::cell_ctl_type        ctl,
   input  logic [cfq_pkg::IDX_W-1:0]    slot_index,
   input  logic [cfq_pkg::WORD_W-1:0]   next_word,
   output logic [cfq_pkg::WORD_W-1:0]   word
);
   logic [cfq_pkg::WORD_W-1:0] word_ff;
   logic [cfq_pkg::WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctl.pop) begin
         word_in = next_word;
      end else if (ctl.push && (ctl.count[cfq_pkg::IDX_W-1:0] == slot_index)) begin
         word_in = ctl.push_word;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
endmodule

// ----- src/circular_fifo_queue.sv -----
// Circular FIFO queue top level: shift chain of word cells, count and capacity.
// Response is registered in the cycle after a word is accepted; 1 word/cycle, set by
// the cell update and registered response stage, unless a held response stalls ready.
// Reset: synchronous; empties the queue, capacity returns to 1024 (saturated to depth).
// Cell contents are not reset. Depends on cfq_pkg, cfq_if, cfq_cell, defines header.
`include "circular_fifo_queue_defines.svh"
module circular_fifo_queue (
   input  logic                        clock,
   input  logic                        reset,
   cfq_req_if.sink                     req_chan,
   cfq_rsp_if.source                   rsp_chan,
   input  logic                        csr_we,
   input  logic [cfq_pkg::CAP_W-1:0]   csr_wdata
);
   localparam int D = cfq_pkg::MAX_DEPTH;
   localparam int W = cfq_pkg::WORD_W;
   localparam int N = cfq_pkg::CNT_W;

   logic [N-1:0]  count_ff, count_in;
   logic [N-1:0]  cap_ff, cap_in;
   logic [W-1:0]  tail_ff, tail_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          ok_ff, ok_in;
   logic [W-1:0]  head_out_ff, head_out_in;
   logic [W-1:0]  tail_out_ff, tail_out_in;
   logic          empty_ff, empty_in;
   logic          full_ff, full_in;

   logic [W-1:0]  words [D+1];
   cfq_pkg::cell_ctl_type ctl;
   logic          fire, is_push, is_pop, push_ok, pop_ok;
   logic          empty_rsp_ok, push_now, tail_match;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire    = req_chan.valid && req_chan.ready;
   assign is_push = (req_chan.kind == cfq_pkg::KIND_PUSH);
   assign is_pop  = (req_chan.kind == cfq_pkg::KIND_POP);
   assign push_ok = is_push && (count_ff < cap_ff);
   assign pop_ok  = is_pop && (count_ff != '0);

   assign ctl.pop       = fire && pop_ok;
   assign ctl.push      = fire && push_ok;
   assign ctl.count     = count_ff;
   assign ctl.push_word = req_chan.push_value;

   assign words[D] = '0;

   for (genvar i = 0; i < D; i++) begin : g_cell
      cfq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .slot_index (cfq_pkg::IDX_W'(i)),
         .next_word  (words[i+1]),
         .word       (words[i])
      );
   end

   always_comb begin
      cap_in = cap_ff;
      if ({21'd0, csr_wdata} == 32'd0) begin
         cap_in = N'(1);
      end else if ({21'd0, csr_wdata} > 32'(D)) begin
         cap_in = N'(D);
      end else begin
         cap_in = N'(csr_wdata);
      end
   end

   always_comb begin
      count_in     = count_ff;
      tail_in      = tail_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ok_in        = ok_ff;
      head_out_in  = head_out_ff;
      tail_out_in  = tail_out_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;
      if (ctl.push) begin
         count_in = count_ff + N'(1);
         tail_in  = req_chan.push_value;
      end else if (ctl.pop) begin
         count_in = count_ff - N'(1);
      end
      if (fire) begin
         rsp_valid_in = 1'b1;
         ok_in        = !(is_push && !push_ok) && !(is_pop && !pop_ok);
         empty_in     = (count_in == '0);
         full_in      = (count_in == cap_ff);
         if (count_in == '0) begin
            head_out_in = '1;
            tail_out_in = '1;
         end else begin
            tail_out_in = tail_in;
            if (ctl.pop) begin
               head_out_in = words[1];
            end else if (count_ff == '0) begin
               head_out_in = req_chan.push_value;
            end else begin
               head_out_in = words[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cap_ff       <= cfq_pkg::CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else if (csr_we) begin
         count_ff     <= '0;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tail_ff     <= tail_in;
      ok_ff       <= ok_in;
      head_out_ff <= head_out_in;
      tail_out_ff <= tail_out_in;
      empty_ff    <= empty_in;
      full_ff     <= full_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.accepted   = ok_ff;
   assign rsp_chan.head_value = head_out_ff;
   assign rsp_chan.tail_value = tail_out_ff;
   assign rsp_chan.empty_flag = empty_ff;
   assign rsp_chan.full_flag  = full_ff;

   assign empty_rsp_ok = !(rsp_valid_ff && empty_ff) ||
                         ((head_out_ff == '1) && (tail_out_ff == '1));
   assign push_now     = ctl.push && !csr_we;
   assign tail_match   = (tail_out_ff == tail_ff);

   `CFQ_ASSERT(a_count_in_cap, clock, reset, count_ff <= cap_ff, "count above capacity")
   `CFQ_ASSERT(a_empty_reads_ones, clock, reset, empty_rsp_ok, "empty response not all ones")
   `CFQ_ASSERT_NEXT(a_push_tail, clock, reset, push_now, tail_match, "tail is not the pushed word")
endmodule
